// File: rtl/abkf_pkg.sv
// abkf_pkg: widths, reset values, register indexes and saturation helpers
// for the angle/bias Kalman filter. No dependencies.
`timescale 1ns / 1ps
package abkf_pkg;

	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_ANGLE_NOISE    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BIAS_NOISE     = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MEAS_NOISE     = 2'd3;

	localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd16777;
	localparam logic [31:0] RST_ANGLE_NOISE   = 32'd16777;
	localparam logic [31:0] RST_BIAS_NOISE    = 32'd83886;
	localparam logic [31:0] RST_MEAS_NOISE    = 32'd8388608;
	localparam logic signed [31:0] COV_ONE    = 32'sd16777216;

	// multiply operand widths: a is signed, b is a signed 33-bit word
	localparam int MulAW = 42;
	localparam int MulBW = 33;
	localparam int MulHW = MulAW + 1;
	localparam int MulRW = MulHW + MulBW - 24;   // floor(a*b / 2^24)
	localparam int SumW  = MulRW + 1;
	localparam int DivW  = 56;                   // |num| << 24

	typedef logic signed [SumW-1:0] sum_t;

	function automatic logic signed [31:0] sat_s32(input sum_t x);
		if (x > sum_t'(64'sd2147483647))
			return 32'sh7fffffff;
		else if (x < -sum_t'(64'sd2147483648))
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [39:0] sat_s40(input sum_t x);
		if (x > sum_t'(64'sd549755813887))
			return 40'sh7fffffffff;
		else if (x < -sum_t'(64'sd549755813888))
			return 40'sh8000000000;
		else
			return x[39:0];
	endfunction

endpackage

// File: rtl/angle_bias_kalman_filter_unit.sv
// angle_bias_kalman_filter_unit: two-state (angle, gyro bias) Kalman filter
// with a shared shift-add multiplier and a restoring divider. Uses abkf_pkg.
//
//   channel  signals                               direction
//   in       in_valid in_stall accel_angle gyro_rate   sink
//   out      out_valid out_stall angle_estimate        source
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    sink
//
// Each item takes ten multiplies (one multiplier bit per cycle) and two gain
// divisions (one quotient bit per cycle), plus the load and write-back states
// around them and the output state S_OUT. With a non-positive innovation
// variance the divisions are skipped and the item goes on to the correction.
// Reset loads the register defaults, zero angle and bias, identity covariance.
// in_stall is high whenever an item is in work. A finished result waits in the
// output register; the next item may start meanwhile.
`timescale 1ns / 1ps
module angle_bias_kalman_filter_unit import abkf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  accel_angle,
	input  logic signed [15:0]  gyro_rate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [23:0]  angle_estimate,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MLOAD = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_MWB   = 3'd3;
	localparam logic [2:0] S_DLOAD = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_DWB   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam logic [3:0] OP_ANG_PRED = 4'd0;
	localparam logic [3:0] OP_AA_PRED  = 4'd1;
	localparam logic [3:0] OP_AB_PRED  = 4'd2;
	localparam logic [3:0] OP_BB_PRED  = 4'd3;
	localparam logic [3:0] OP_AA_CORR  = 4'd4;
	localparam logic [3:0] OP_AB_CORR  = 4'd5;
	localparam logic [3:0] OP_BA_CORR  = 4'd6;
	localparam logic [3:0] OP_BB_CORR  = 4'd7;
	localparam logic [3:0] OP_ANG_CORR = 4'd8;
	localparam logic [3:0] OP_BIAS_CORR = 4'd9;

	logic [31:0] dt_q, qa_q, qg_q, r_q;
	logic signed [39:0] angle_q, bias_q;
	logic signed [31:0] aa_q, ab_q, ba_q, bb_q;
	logic signed [15:0] meas_q, rate_q;
	logic signed [40:0] err_q;
	logic signed [31:0] t0_q, t1_q, k0_q, k1_q;
	logic [33:0] e_q;
	logic [2:0] state_q;
	logic [3:0] op_q;
	logic [5:0] cnt_q;
	logic div_sel_q;
	logic signed [MulAW-1:0] ma_q;
	logic [MulBW-1:0] mb_q;
	logic signed [MulHW-1:0] mh_q;
	logic [MulBW-1:0] ml_q;
	logic [33:0] rem_q;
	logic [DivW-1:0] dq_q;
	logic dneg_q;
	logic out_valid_q;
	logic signed [23:0] angle_estimate_q;

	logic signed [MulAW-1:0] ma_d;
	logic [MulBW-1:0] mb_d;
	logic signed [MulHW-1:0] m_addend, m_sum;
	logic signed [MulRW-1:0] mres;
	logic signed [34:0] e_full;
	logic e_pos;
	logic signed [40:0] err_d;
	logic signed [31:0] div_num;
	logic [31:0] div_mag;
	logic [34:0] rem_sh;
	logic [35:0] rem_diff;
	logic rem_ge;
	logic signed [31:0] k_d;
	logic signed [31:0] ang_sh;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign angle_estimate = angle_estimate_q;
	assign out_free = !out_valid_q || !out_stall;

	// multiplier operands per operation
	always_comb begin
		ma_d = '0;
		mb_d = {1'b0, dt_q};
		unique case (op_q)
			OP_ANG_PRED:  ma_d = MulAW'($signed({rate_q, 16'b0})) - MulAW'(bias_q);
			OP_AA_PRED:   ma_d = MulAW'($signed({1'b0, qa_q})) - MulAW'(ab_q) - MulAW'(ba_q);
			OP_AB_PRED:   ma_d = -MulAW'(bb_q);
			OP_BB_PRED:   ma_d = MulAW'($signed({1'b0, qg_q}));
			OP_AA_CORR:   begin ma_d = MulAW'(t0_q); mb_d = {k0_q[31], k0_q}; end
			OP_AB_CORR:   begin ma_d = MulAW'(t1_q); mb_d = {k0_q[31], k0_q}; end
			OP_BA_CORR:   begin ma_d = MulAW'(t0_q); mb_d = {k1_q[31], k1_q}; end
			OP_BB_CORR:   begin ma_d = MulAW'(t1_q); mb_d = {k1_q[31], k1_q}; end
			OP_ANG_CORR:  begin ma_d = MulAW'(err_q); mb_d = {k0_q[31], k0_q}; end
			OP_BIAS_CORR: begin ma_d = MulAW'(err_q); mb_d = {k1_q[31], k1_q}; end
			default:      ma_d = '0;
		endcase
	end

	// one multiplier bit per cycle, LSB first; the top bit has negative weight
	always_comb begin
		m_addend = mb_q[0] ? MulHW'(ma_q) : '0;
		if (cnt_q == 6'(MulBW - 1))
			m_sum = mh_q - m_addend;
		else
			m_sum = mh_q + m_addend;
	end
	assign mres = $signed({mh_q, ml_q[MulBW-1:24]});

	assign e_full = $signed({3'b0, r_q}) + 35'(aa_q);
	assign e_pos = !e_full[34] && (e_full != '0);
	assign err_d = $signed({meas_q, 16'b0}) - 41'(angle_q);

	assign div_num = div_sel_q ? ba_q : aa_q;
	assign div_mag = div_num[31] ? 32'(-div_num) : div_num;

	assign rem_sh = {rem_q, dq_q[DivW-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b0, e_q};
	assign rem_ge = !rem_diff[35];

	// quotient sits in dq_q after the last step
	always_comb begin
		if (dneg_q)
			k_d = (dq_q > DivW'(64'd2147483648)) ? 32'sh80000000 : 32'(-dq_q);
		else
			k_d = (dq_q > DivW'(64'd2147483647)) ? 32'sh7fffffff : dq_q[31:0];
	end

	assign ang_sh = 32'(angle_q >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= RST_SAMPLE_PERIOD;
			qa_q <= RST_ANGLE_NOISE;
			qg_q <= RST_BIAS_NOISE;
			r_q <= RST_MEAS_NOISE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD: dt_q <= cfg_data;
				REG_ANGLE_NOISE:   qa_q <= cfg_data;
				REG_BIAS_NOISE:    qg_q <= cfg_data;
				REG_MEAS_NOISE:    r_q <= cfg_data;
				default:           dt_q <= dt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ANG_PRED;
			cnt_q <= '0;
			div_sel_q <= 1'b0;
			out_valid_q <= 1'b0;
			angle_q <= '0;
			bias_q <= '0;
			aa_q <= COV_ONE;
			ab_q <= '0;
			ba_q <= '0;
			bb_q <= COV_ONE;
		end else begin
			// S_OUT handles the output register itself
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						meas_q <= accel_angle;
						rate_q <= gyro_rate;
						op_q <= OP_ANG_PRED;
						state_q <= S_MLOAD;
					end
				end
				S_MLOAD: begin
					ma_q <= ma_d;
					mb_q <= mb_d;
					mh_q <= '0;
					cnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mh_q <= {m_sum[MulHW-1], m_sum[MulHW-1:1]};
					ml_q <= {m_sum[0], ml_q[MulBW-1:1]};
					mb_q <= {1'b0, mb_q[MulBW-1:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MulBW - 1))
						state_q <= S_MWB;
				end
				S_MWB: begin
					unique case (op_q)
						OP_ANG_PRED:  angle_q <= sat_s40(sum_t'(angle_q) + sum_t'(mres));
						OP_AA_PRED:   aa_q <= sat_s32(sum_t'(aa_q) + sum_t'(mres));
						OP_AB_PRED: begin
							ab_q <= sat_s32(sum_t'(ab_q) + sum_t'(mres));
							ba_q <= sat_s32(sum_t'(ba_q) + sum_t'(mres));
						end
						OP_BB_PRED:   bb_q <= sat_s32(sum_t'(bb_q) + sum_t'(mres));
						OP_AA_CORR:   aa_q <= sat_s32(sum_t'(aa_q) - sum_t'(mres));
						OP_AB_CORR:   ab_q <= sat_s32(sum_t'(ab_q) - sum_t'(mres));
						OP_BA_CORR:   ba_q <= sat_s32(sum_t'(ba_q) - sum_t'(mres));
						OP_BB_CORR:   bb_q <= sat_s32(sum_t'(bb_q) - sum_t'(mres));
						OP_ANG_CORR:  angle_q <= sat_s40(sum_t'(angle_q) + sum_t'(mres));
						OP_BIAS_CORR: bias_q <= sat_s40(sum_t'(bias_q) + sum_t'(mres));
						default:      angle_q <= angle_q;
					endcase
					if (op_q == OP_BB_PRED) begin
						div_sel_q <= 1'b0;
						state_q <= S_DLOAD;
					end else if (op_q == OP_BIAS_CORR) begin
						state_q <= S_OUT;
					end else begin
						op_q <= op_q + 4'd1;
						state_q <= S_MLOAD;
					end
				end
				S_DLOAD: begin
					if (!div_sel_q) begin
						e_q <= e_full[33:0];
						err_q <= err_d;
						t0_q <= aa_q;
						t1_q <= ab_q;
					end
					if (!div_sel_q && !e_pos) begin
						// no useful innovation variance: zero gains
						k0_q <= '0;
						k1_q <= '0;
						op_q <= OP_AA_CORR;
						state_q <= S_MLOAD;
					end else begin
						rem_q <= '0;
						dq_q <= {div_mag, 24'b0};
						dneg_q <= div_num[31];
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_ge ? rem_diff[33:0] : rem_sh[33:0];
					dq_q <= {dq_q[DivW-2:0], rem_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DivW - 1))
						state_q <= S_DWB;
				end
				S_DWB: begin
					if (!div_sel_q) begin
						k0_q <= k_d;
						div_sel_q <= 1'b1;
						state_q <= S_DLOAD;
					end else begin
						k1_q <= k_d;
						op_q <= OP_AA_CORR;
						state_q <= S_MLOAD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (ang_sh > 32'sd8388607)
							angle_estimate_q <= 24'sh7fffff;
						else if (ang_sh < -32'sd8388608)
							angle_estimate_q <= 24'sh800000;
						else
							angle_estimate_q <= ang_sh[23:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
